[sv/coulomb_counting_fuel_gauge_core_macros.svh]
// Assertion macros shared by the fuel gauge RTL.
`ifndef COULOMB_COUNTING_FUEL_GAUGE_CORE_MACROS_SVH
`define COULOMB_COUNTING_FUEL_GAUGE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define CCFG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CCFG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CCFG_ASSERT(lbl, clk, rst, prop, msg)
`define CCFG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[sv/ccfg_pkg.sv]
// Widths, constants, step table and state codes of the fuel gauge.
package ccfg_pkg;

   localparam int TIME_W      = 32;
   localparam int CUR_W       = 16;
   localparam int MV_W        = 15;
   localparam int CAP_W       = 16;
   localparam int CELL_W      = 5;
   localparam int CALIB_W     = 15;
   localparam int PCT_W       = 7;
   localparam int MAH_W       = 16;
   localparam int CHARGE_W    = 38;
   localparam int PROD_W      = CUR_W + TIME_W;
   localparam int DIFF_W      = PROD_W + 2;
   localparam int K_W         = 22;
   localparam int THR_W       = 16;
   localparam int MV_STEP_W   = 11;
   localparam int BLEND_NUM_W = CHARGE_W + 3;
   localparam int FIVE_W      = 3;
   localparam int PCT_NUM_W   = CHARGE_W + 7;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int STEP_N      = 6;

   localparam logic [K_W-1:0]    MS_PER_HOUR = 22'd3600000;
   localparam logic [K_W-1:0]    FULL_K      = MS_PER_HOUR;
   localparam logic [FIVE_W-1:0] BLEND_DIV   = 3'd5;
   localparam logic [PCT_W-1:0]  PCT_MAX     = 7'd100;

   localparam logic [MV_STEP_W-1:0] FULL_MV_PER_CELL  = 11'd1450;
   localparam logic [MV_STEP_W-1:0] EMPTY_MV_PER_CELL = 11'd1000;

   // per-cell step thresholds and the matching charge per mAh of capacity
   localparam logic [MV_STEP_W-1:0] STEP_MV [STEP_N] =
      '{11'd1300, 11'd1250, 11'd1200, 11'd1150, 11'd1100, 11'd1050};
   localparam logic [K_W-1:0] STEP_K [STEP_N] =
      '{22'd3240000, 22'd2880000, 22'd1800000, 22'd1080000, 22'd540000, 22'd180000};

   localparam logic [CAP_W-1:0]   RST_FULL_CAPACITY = 16'd2450;
   localparam logic [CELL_W-1:0]  RST_CELL_COUNT    = 5'd8;
   localparam logic [CALIB_W-1:0] RST_CALIB_CURRENT = 15'd50;
   localparam logic [PCT_W-1:0]   RST_LOW_ALARM     = 7'd25;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FULL_CAPACITY = 2'd0,
      CSR_CELL_COUNT    = 2'd1,
      CSR_CALIB_CURRENT = 2'd2,
      CSR_LOW_ALARM     = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIRST,
      ST_MUL,
      ST_SUM,
      ST_CLAMP,
      ST_BLEND,
      ST_BLEND_WAIT,
      ST_PREP1,
      ST_PREP2,
      ST_DIVS,
      ST_DIV_WAIT,
      ST_RESULT
   } state_type;

endpackage

[sv/ccfg_smul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module ccfg_smul import ccfg_pkg::*; #(
   parameter int A_W = CUR_W,
   parameter int B_W = TIME_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [A_W-1:0]       a,
   input  logic [B_W-1:0]       b,
   output logic                 done,
   output logic [A_W+B_W-1:0]   prod
);
   localparam int P_W   = A_W + B_W;
   localparam int CNT_W = $clog2(A_W);

   logic [P_W-1:0]   prod_ff;
   logic [P_W-1:0]   prod_in;
   logic [B_W-1:0]   b_ff;
   logic [B_W:0]     sum;
   logic [CNT_W-1:0] cnt_ff;
   logic             run_ff;
   logic             done_ff;

   always_comb begin
      sum     = {1'b0, prod_ff[P_W-1:A_W]} + (prod_ff[0] ? {1'b0, b_ff} : '0);
      prod_in = {sum, prod_ff[A_W-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(A_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= {{B_W{1'b0}}, a};
         b_ff    <= b;
      end else if (run_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

[sv/ccfg_sdiv.sv]
// Restoring divider, one quotient bit per cycle.
module ccfg_sdiv import ccfg_pkg::*; #(
   parameter int NUM_W = PCT_NUM_W,
   parameter int DEN_W = CHARGE_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);
   localparam int CNT_W = $clog2(NUM_W);

   logic [NUM_W-1:0] work_ff;
   logic [NUM_W-1:0] work_in;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W+1:0] diff;
   logic             fits;
   logic [CNT_W-1:0] cnt_ff;
   logic             run_ff;
   logic             done_ff;

   // shift the next numerator bit into the remainder, subtract when it fits
   always_comb begin
      trial   = {rem_ff, work_ff[NUM_W-1]};
      diff    = {1'b0, trial} - {2'b00, den_ff};
      fits    = !diff[DEN_W+1];
      rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      work_in = {work_ff[NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= num;
         rem_ff  <= '0;
         den_ff  <= den;
      end else if (run_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

   assign done = done_ff;
   assign quo  = work_ff;

endmodule

[sv/ccfg_est.sv]
// Full charge and voltage-based charge estimate from the per-cell step table.
module ccfg_est import ccfg_pkg::*; (
   input  logic                clock,
   input  logic [MV_W-1:0]     bus_mv,
   input  logic [CELL_W-1:0]   cell_count,
   input  logic [CAP_W-1:0]    capacity_mah,
   output logic [CHARGE_W-1:0] est,
   output logic [CHARGE_W-1:0] full_mams
);
   logic [THR_W-1:0]    mv_ext;
   logic [THR_W-1:0]    full_thr;
   logic [THR_W-1:0]    empty_thr;
   logic [K_W-1:0]      k_step;
   logic [K_W-1:0]      k_in;
   logic [K_W-1:0]      k_ff;
   logic [CHARGE_W-1:0] est_ff;
   logic [CHARGE_W-1:0] full_ff;

   assign mv_ext    = THR_W'(bus_mv);
   assign full_thr  = THR_W'(FULL_MV_PER_CELL) * THR_W'(cell_count);
   assign empty_thr = THR_W'(EMPTY_MV_PER_CELL) * THR_W'(cell_count);

   // the highest step that the voltage reaches wins
   always_comb begin
      k_step = '0;
      for (int i = STEP_N - 1; i >= 0; i--) begin
         if (mv_ext >= THR_W'(STEP_MV[i]) * THR_W'(cell_count)) begin
            k_step = STEP_K[i];
         end
      end
      priority if (mv_ext >= full_thr) begin
         k_in = FULL_K;
      end else if (mv_ext <= empty_thr) begin
         k_in = '0;
      end else begin
         k_in = k_step;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      est_ff  <= CHARGE_W'(capacity_mah) * CHARGE_W'(k_ff);
      full_ff <= CHARGE_W'(capacity_mah) * CHARGE_W'(MS_PER_HOUR);
   end

   assign est       = est_ff;
   assign full_mams = full_ff;

endmodule

[sv/coulomb_counting_fuel_gauge_core.sv]
// Coulomb-counting fuel gauge top level: control sequencer, state and ports.
//
// One battery sample is taken at a time; the input stalls until its result is
// in the output register. The serial units set the pace: a 16-step multiply of
// current by elapsed time, a 41-step divide by five for the low-current voltage
// blend, and the 45-step percentage divide, which runs alongside the 38-step
// mAh divide. Configuration writes are always taken (csr_ready is tied high)
// and must be made while no sample is in flight.
`include "coulomb_counting_fuel_gauge_core_macros.svh"
module coulomb_counting_fuel_gauge_core import ccfg_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [TIME_W-1:0]       req_time_ms,
   input  logic signed [CUR_W-1:0] req_current_ma,
   input  logic [MV_W-1:0]         req_bus_mv,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [MAH_W-1:0]        rsp_remaining_mah,
   output logic [PCT_W-1:0]        rsp_percent,
   output logic                    rsp_low_alarm,
   output logic                    rsp_calibrated,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);
   state_type state_ff;
   state_type state_in;

   logic [CAP_W-1:0]     full_capacity_ff;
   logic [CELL_W-1:0]    cell_count_ff;
   logic [CALIB_W-1:0]   calib_current_ff;
   logic [PCT_W-1:0]     low_alarm_pct_ff;

   logic [CHARGE_W-1:0]  charge_ff;
   logic [TIME_W-1:0]    last_time_ff;
   logic                 have_prev_ff;
   logic                 low_alarm_ff;
   logic                 cur_neg_ff;
   logic [CUR_W-1:0]     mag_ff;
   logic [MV_W-1:0]      mv_ff;
   logic                 calibrated_ff;
   logic [DIFF_W-1:0]    diff_ff;
   logic [PCT_NUM_W-1:0] c100_ff;

   logic                 rsp_valid_ff;
   logic [MAH_W-1:0]     rsp_mah_ff;
   logic [PCT_W-1:0]     rsp_pct_ff;
   logic                 rsp_alarm_ff;
   logic                 rsp_cal_ff;

   logic                 mul_start;
   logic                 blend_start;
   logic                 divs_start;
   logic                 rsp_load;
   logic                 rsp_free;
   logic                 calib_hit;
   logic [TIME_W-1:0]    dt;
   logic [CUR_W-1:0]     mag;

   logic [CHARGE_W-1:0]    est;
   logic [CHARGE_W-1:0]    full_mams;
   logic                   mul_done;
   logic [PROD_W-1:0]      mul_prod;
   logic [BLEND_NUM_W-1:0] blend_num;
   logic                   blend_done;
   logic [BLEND_NUM_W-1:0] blend_quo;
   logic                   mah_done;
   logic [CHARGE_W-1:0]    mah_quo;
   logic                   pct_done;
   logic [PCT_NUM_W-1:0]   pct_quo;
   logic [PCT_W-1:0]       pct_val;
   logic                   alarm_hit;

   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign dt        = req_time_ms - last_time_ff;
   assign mag       = req_current_ma[CUR_W-1] ? CUR_W'(-req_current_ma)
                                              : CUR_W'(req_current_ma);
   assign calib_hit = mag_ff < CUR_W'(calib_current_ff);
   assign blend_num = BLEND_NUM_W'({charge_ff, 2'b00}) + BLEND_NUM_W'(est);

   always_comb begin
      priority if (full_mams == '0) begin
         pct_val = '0;
      end else if (pct_quo > PCT_NUM_W'(PCT_MAX)) begin
         pct_val = PCT_MAX;
      end else begin
         pct_val = PCT_W'(pct_quo);
      end
   end
   assign alarm_hit = pct_val < low_alarm_pct_ff;

   ccfg_est u_est (
      .clock        (clock),
      .bus_mv       (mv_ff),
      .cell_count   (cell_count_ff),
      .capacity_mah (full_capacity_ff),
      .est          (est),
      .full_mams    (full_mams)
   );

   ccfg_smul #(.A_W(CUR_W), .B_W(TIME_W)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mag),
      .b     (dt),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   ccfg_sdiv #(.NUM_W(BLEND_NUM_W), .DEN_W(FIVE_W)) u_div_blend (
      .clock (clock),
      .reset (reset),
      .start (blend_start),
      .num   (blend_num),
      .den   (BLEND_DIV),
      .done  (blend_done),
      .quo   (blend_quo)
   );

   ccfg_sdiv #(.NUM_W(CHARGE_W), .DEN_W(K_W)) u_div_mah (
      .clock (clock),
      .reset (reset),
      .start (divs_start),
      .num   (charge_ff),
      .den   (MS_PER_HOUR),
      .done  (mah_done),
      .quo   (mah_quo)
   );

   ccfg_sdiv #(.NUM_W(PCT_NUM_W), .DEN_W(CHARGE_W)) u_div_pct (
      .clock (clock),
      .reset (reset),
      .start (divs_start),
      .num   (c100_ff),
      .den   (full_mams),
      .done  (pct_done),
      .quo   (pct_quo)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         full_capacity_ff <= RST_FULL_CAPACITY;
         cell_count_ff    <= RST_CELL_COUNT;
         calib_current_ff <= RST_CALIB_CURRENT;
         low_alarm_pct_ff <= RST_LOW_ALARM;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_FULL_CAPACITY: full_capacity_ff <= csr_wdata[CAP_W-1:0];
            CSR_CELL_COUNT:    cell_count_ff    <= csr_wdata[CELL_W-1:0];
            CSR_CALIB_CURRENT: calib_current_ff <= csr_wdata[CALIB_W-1:0];
            CSR_LOW_ALARM:     low_alarm_pct_ff <= csr_wdata[PCT_W-1:0];
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = have_prev_ff ? ST_MUL : ST_FIRST;
            end
         end
         ST_FIRST:      state_in = ST_PREP1;
         ST_MUL:        if (mul_done) state_in = ST_SUM;
         ST_SUM:        state_in = ST_CLAMP;
         ST_CLAMP:      state_in = calib_hit ? ST_BLEND : ST_PREP1;
         ST_BLEND:      state_in = ST_BLEND_WAIT;
         ST_BLEND_WAIT: if (blend_done) state_in = ST_PREP1;
         ST_PREP1:      state_in = ST_PREP2;
         ST_PREP2:      state_in = ST_DIVS;
         ST_DIVS:       state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:   if (pct_done) state_in = ST_RESULT;
         ST_RESULT:     if (rsp_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall   = 1'b1;
      mul_start   = 1'b0;
      blend_start = 1'b0;
      divs_start  = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            mul_start = req_valid && have_prev_ff;
         end
         ST_BLEND:  blend_start = 1'b1;
         ST_DIVS:   divs_start  = 1'b1;
         ST_RESULT: rsp_load    = rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_prev_ff <= 1'b0;
         low_alarm_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE && req_valid) begin
            have_prev_ff <= 1'b1;
         end
         if (rsp_load) begin
            low_alarm_ff <= low_alarm_ff | alarm_hit;
         end
         // hold the result until the transfer, refill as soon as it leaves
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               last_time_ff  <= req_time_ms;
               cur_neg_ff    <= req_current_ma[CUR_W-1];
               mag_ff        <= mag;
               mv_ff         <= req_bus_mv;
               calibrated_ff <= 1'b0;
            end
         end
         ST_FIRST: charge_ff <= full_mams;
         ST_SUM: begin
            // negative current charges the battery
            diff_ff <= cur_neg_ff ? DIFF_W'(charge_ff) + DIFF_W'(mul_prod)
                                  : DIFF_W'(charge_ff) - DIFF_W'(mul_prod);
         end
         ST_CLAMP: begin
            priority if (diff_ff[DIFF_W-1]) begin
               charge_ff <= '0;
            end else if (diff_ff > DIFF_W'(full_mams)) begin
               charge_ff <= full_mams;
            end else begin
               charge_ff <= CHARGE_W'(diff_ff);
            end
            calibrated_ff <= calib_hit;
         end
         ST_BLEND_WAIT: begin
            if (blend_done) begin
               charge_ff <= CHARGE_W'(blend_quo);
            end
         end
         ST_PREP1: c100_ff <= PCT_NUM_W'({charge_ff, 5'b0}) + PCT_NUM_W'({charge_ff, 2'b0});
         ST_PREP2: c100_ff <= c100_ff + PCT_NUM_W'({charge_ff, 6'b0});
         ST_RESULT: begin
            if (rsp_load) begin
               rsp_mah_ff   <= MAH_W'(mah_quo);
               rsp_pct_ff   <= pct_val;
               rsp_alarm_ff <= low_alarm_ff | alarm_hit;
               rsp_cal_ff   <= calibrated_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_remaining_mah = rsp_mah_ff;
   assign rsp_percent       = rsp_pct_ff;
   assign rsp_low_alarm     = rsp_alarm_ff;
   assign rsp_calibrated    = rsp_cal_ff;

   `CCFG_ASSERT_NEXT(a_alarm_sticky, clock, reset, low_alarm_ff, low_alarm_ff, "alarm latch dropped")
   `CCFG_ASSERT(a_mul_done_in_mul, clock, reset, mul_done |-> (state_ff == ST_MUL), "multiply finished outside its state")
   `CCFG_ASSERT(a_mah_done_in_wait, clock, reset, mah_done |-> (state_ff == ST_DIV_WAIT), "mAh divide late")
   `CCFG_ASSERT(a_charge_bound, clock, reset, (state_ff == ST_PREP1) |-> (charge_ff <= full_mams), "charge above full")
   `CCFG_ASSERT(a_pct_bound, clock, reset, (state_ff == ST_RESULT && full_mams != '0) |-> (pct_quo <= PCT_NUM_W'(PCT_MAX)), "percent quotient above limit")

endmodule

[dv/tb_coulomb_counting_fuel_gauge_core.sv]
// Self-checking testbench of the coulomb-counting fuel gauge core.
module tb_coulomb_counting_fuel_gauge_core;
   import ccfg_pkg::*;

   localparam longint unsigned MS_HOUR = 64'd3600000;
   localparam int unsigned STEP_MV_CELL [6] = '{1300, 1250, 1200, 1150, 1100, 1050};
   localparam int unsigned STEP_PERCENT [6] = '{90, 80, 50, 30, 15, 5};
   localparam int unsigned EDGE_MV_CELL [8] = '{1450, 1300, 1250, 1200, 1150, 1100, 1050, 1000};
   localparam int END_SETTLE = 120;

   typedef struct packed {
      logic [MAH_W-1:0] remaining_mah;
      logic [PCT_W-1:0] percent;
      logic             low_alarm;
      logic             calibrated;
   } gauge_reading_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [TIME_W-1:0]       req_time_ms;
   logic signed [CUR_W-1:0] req_current_ma;
   logic [MV_W-1:0]         req_bus_mv;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [MAH_W-1:0]        rsp_remaining_mah;
   logic [PCT_W-1:0]        rsp_percent;
   logic                    rsp_low_alarm;
   logic                    rsp_calibrated;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   // register copies and gauge state of the predictor
   logic [CAP_W-1:0]   cfg_capacity;
   logic [CELL_W-1:0]  cfg_cells;
   logic [CALIB_W-1:0] cfg_calib;
   logic [PCT_W-1:0]   cfg_alarm;
   longint unsigned    gauge_charge;
   logic [TIME_W-1:0]  gauge_last_ms;
   logic               gauge_started;
   logic               gauge_alarm;

   gauge_reading_type pending_readings[$];
   logic [TIME_W-1:0] now_ms;
   bit quiet;
   int errors;

   coulomb_counting_fuel_gauge_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_time_ms      (req_time_ms),
      .req_current_ma   (req_current_ma),
      .req_bus_mv       (req_bus_mv),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_remaining_mah(rsp_remaining_mah),
      .rsp_percent      (rsp_percent),
      .rsp_low_alarm    (rsp_low_alarm),
      .rsp_calibrated   (rsp_calibrated),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // charge that the bus voltage alone points to
   function automatic longint unsigned voltage_charge(input logic [MV_W-1:0] mv,
                                                      input longint unsigned full_mams);
      longint unsigned n;
      longint unsigned v;
      n = cfg_cells;
      v = mv;
      if (v >= 1450 * n) return full_mams;
      if (v <= 1000 * n) return 0;
      for (int i = 0; i < 6; i++) begin
         if (v >= STEP_MV_CELL[i] * n) begin
            return longint'(cfg_capacity) * 36000 * STEP_PERCENT[i];
         end
      end
      return 0;
   endfunction

   function automatic gauge_reading_type gauge_predict(input logic [TIME_W-1:0] t,
                                                       input logic signed [CUR_W-1:0] cur,
                                                       input logic [MV_W-1:0] mv);
      gauge_reading_type r;
      longint unsigned full_mams;
      longint unsigned pct;
      logic [TIME_W-1:0] dt;
      longint cur_l;
      longint dt_l;
      longint nxt;
      longint mag;
      full_mams = cfg_capacity;
      full_mams = full_mams * MS_HOUR;
      r.calibrated = 1'b0;
      if (!gauge_started) begin
         gauge_charge = full_mams;
         gauge_started = 1'b1;
      end else begin
         dt = t - gauge_last_ms;   // wraps modulo 2^32
         dt_l = dt;
         cur_l = cur;
         nxt = longint'(gauge_charge) - cur_l * dt_l;
         if (nxt < 0) nxt = 0;
         if (nxt > longint'(full_mams)) nxt = longint'(full_mams);
         gauge_charge = nxt;
         mag = (cur_l < 0) ? -cur_l : cur_l;
         if (mag < longint'(cfg_calib)) begin
            gauge_charge = (4 * gauge_charge + voltage_charge(mv, full_mams)) / 5;
            r.calibrated = 1'b1;
         end
      end
      gauge_last_ms = t;
      pct = (full_mams == 0) ? 0 : (gauge_charge * 100) / full_mams;
      if (pct > 100) pct = 100;
      if (pct < cfg_alarm) gauge_alarm = 1'b1;
      r.remaining_mah = MAH_W'(gauge_charge / MS_HOUR);
      r.percent = PCT_W'(pct);
      r.low_alarm = gauge_alarm;
      return r;
   endfunction

   // result side: random stall, check every transfer against the oldest prediction
   always @(negedge clock) begin
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 34);
   end

   always @(posedge clock) begin : check_readings
      gauge_reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            $error("result transfer with no sample pending");
            errors++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_remaining_mah !== want.remaining_mah) begin
               $error("remaining_mah expected %0d actual %0d", want.remaining_mah,
                      rsp_remaining_mah);
               errors++;
            end
            if (rsp_percent !== want.percent) begin
               $error("percent expected %0d actual %0d", want.percent, rsp_percent);
               errors++;
            end
            if (rsp_low_alarm !== want.low_alarm) begin
               $error("low_alarm expected %0d actual %0d", want.low_alarm, rsp_low_alarm);
               errors++;
            end
            if (rsp_calibrated !== want.calibrated) begin
               $error("calibrated expected %0d actual %0d", want.calibrated, rsp_calibrated);
               errors++;
            end
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_sample(input logic [TIME_W-1:0] t, input logic signed [CUR_W-1:0] cur,
                              input logic [MV_W-1:0] mv);
      int gap;
      gap = 0;
      if (!quiet) begin
         if ($urandom_range(0, 99) < 5) gap = $urandom_range(1, 130);
         else while ($urandom_range(0, 99) < 34) gap++;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_time_ms    <= t;
      req_current_ma <= cur;
      req_bus_mv     <= mv;
      do @(posedge clock); while (req_stall);
      pending_readings.push_back(gauge_predict(t, cur, mv));
      now_ms = t;
      @(negedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FULL_CAPACITY: cfg_capacity = data[CAP_W-1:0];
         CSR_CELL_COUNT:    cfg_cells    = data[CELL_W-1:0];
         CSR_CALIB_CURRENT: cfg_calib    = data[CALIB_W-1:0];
         CSR_LOW_ALARM:     cfg_alarm    = data[PCT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic wait_idle(input int settle);
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic set_config(input logic [15:0] cap, input logic [15:0] cells,
                             input logic [15:0] calib, input logic [15:0] alarm);
      wait_idle(4);
      write_reg(CSR_FULL_CAPACITY, cap);
      write_reg(CSR_CELL_COUNT, cells);
      write_reg(CSR_CALIB_CURRENT, calib);
      write_reg(CSR_LOW_ALARM, alarm);
      csr_valid <= 1'b0;
   endtask

   // mostly plausible discharge and charge traces, with some wide jumps mixed in
   task automatic random_samples(input int count);
      logic [TIME_W-1:0] t;
      int c;
      int v;
      int r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 60) t = now_ms + $urandom_range(0, 4000);
         else if (r < 80) t = now_ms + $urandom_range(0, 1 << 20);
         else if (r < 90) t = $urandom;
         else t = now_ms;
         r = $urandom_range(0, 99);
         if (r < 40) begin
            c = $urandom_range(0, cfg_calib);
            if ($urandom_range(0, 1)) c = -c;
         end else if (r < 70) begin
            c = $urandom_range(0, 4000);
            c = c - 2000;
         end else if (r < 90) begin
            c = $urandom;
         end else begin
            case ($urandom_range(0, 2))
               0: c = -32768;
               1: c = 32767;
               default: c = 0;
            endcase
         end
         r = $urandom_range(0, 99);
         if (cfg_cells == 0 || r >= 80) begin
            v = $urandom_range(0, 32767);
         end else if (r < 60) begin
            v = cfg_cells * $urandom_range(950, 1500);
         end else begin
            v = cfg_cells * EDGE_MV_CELL[$urandom_range(0, 7)];
            v = v + $urandom_range(0, 2) - 1;
         end
         if (v > 32767) v = 32767;
         send_sample(t, CUR_W'(c), MV_W'(v));
      end
   endtask

   // first sample loads full charge whatever the time stamp
   task automatic test_first_sample();
      send_sample(32'd0, 16'sd32767, 15'd0);
   endtask

   // zero current across every estimate level, then currents at the calib limit
   task automatic test_step_levels();
      int unsigned levels [13] = '{11600, 11599, 10400, 10399, 10000, 9600, 9200,
                                   8800, 8400, 8001, 8000, 0, 32767};
      foreach (levels[i]) send_sample(now_ms + 100, 16'sd0, MV_W'(levels[i]));
      send_sample(now_ms + 100, 16'sd49, 15'd11600);
      send_sample(now_ms + 100, -16'sd49, 15'd8400);
      send_sample(now_ms + 100, 16'sd50, 15'd8400);
      send_sample(now_ms + 100, -16'sd50, 15'd8400);
   endtask

   // timestamp wrap and step back, saturation at full and at empty
   task automatic test_field_extremes();
      send_sample(32'hFFFF_FFF0, 16'sd1000, 15'd0);
      send_sample(32'h0000_0010, 16'sd1000, 15'd0);
      send_sample(32'h0000_0005, 16'sd1, 15'd0);
      send_sample(32'hFFFF_FFFF, -16'sd32768, 15'd32767);
      send_sample(32'h8000_0000, 16'sd32767, 15'd32767);
      wait_idle(4);
   endtask

   task automatic test_capacity_extremes();
      set_config(16'd1, 16'd1, 16'd32767, 16'd0);
      random_samples(50);
      set_config(16'd65535, 16'hFFFF, 16'd0, 16'h00FF);
      random_samples(40);
      set_config(16'd0, 16'd16, 16'd1000, 16'd100);
      random_samples(40);
      wait_idle(4);
   endtask

   task automatic test_cell_count_extremes();
      set_config(16'd40, 16'd0, 16'd200, 16'd50);
      random_samples(40);
      set_config(16'd120, 16'hFFE1, 16'hFFFF, 16'd0);
      random_samples(40);
      wait_idle(4);
   endtask

   task automatic test_quiet_stretch();
      set_config(16'd100, 16'd12, 16'd500, 16'd25);
      quiet = 1'b1;
      random_samples(60);
      wait_idle(4);
      quiet = 1'b0;
   endtask

   task automatic test_random_settings();
      set_config(16'd2450, 16'd8, 16'd50, 16'd10);
      random_samples(40);
      repeat (3) begin
         set_config(16'($urandom_range(1, 500)), 16'($urandom_range(1, 16)),
                    16'($urandom_range(0, 3000)), 16'($urandom_range(0, 100)));
         random_samples(30);
      end
      wait_idle(4);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_time_ms    = '0;
      req_current_ma = '0;
      req_bus_mv     = '0;
      rsp_stall      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      cfg_capacity   = 16'd2450;
      cfg_cells      = 5'd8;
      cfg_calib      = 15'd50;
      cfg_alarm      = 7'd25;
      gauge_charge   = 0;
      gauge_last_ms  = '0;
      gauge_started  = 1'b0;
      gauge_alarm    = 1'b0;
      now_ms         = '0;
      quiet          = 1'b0;
      errors         = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_first_sample();
      test_step_levels();
      test_field_extremes();
      test_capacity_extremes();
      test_cell_count_extremes();
      test_quiet_stretch();
      test_random_settings();

      wait_idle(END_SETTLE);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/ccfg_pkg.sv
sv/ccfg_smul.sv
sv/ccfg_sdiv.sv
sv/ccfg_est.sv
sv/coulomb_counting_fuel_gauge_core.sv
dv/tb_coulomb_counting_fuel_gauge_core.sv
